>>> rtl/line_grep_substring_search_unit_assert.svh
// assertion macros shared by the checker
`ifndef LINE_GREP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define LINE_GREP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define LGSS_ASSERT_NOW(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lgss check failed");

// next-cycle implication, reset masked
`define LGSS_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lgss check failed");

`endif

>>> rtl/lgss_pkg.sv
`default_nettype none

package lgss_pkg;

  // fixed field widths
  localparam int DATA_BITS    = 8;
  localparam int PATTERN_BITS = 64;
  localparam int LEN_BITS     = 4;
  localparam int LINE_BITS    = 32;
  localparam int OUT_OFS_BITS = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int M_TDATA_BITS = LINE_BITS + OUT_OFS_BITS;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_CASE     = 2'd2;

  localparam logic [DATA_BITS-1:0] NEWLINE_BYTE = 8'h0A;

  // result queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [QUEUE_PTR_BITS-1:0] queue_ptr_t;
  typedef logic [QUEUE_CNT_BITS-1:0] queue_cnt_t;

  typedef struct packed {
    logic                    match_found;
    logic [LINE_BITS-1:0]    line_number;
    logic [OUT_OFS_BITS-1:0] line_start_offset;
    logic                    end_of_file;
  } result_t;

  // fold ascii a-z to upper case unless exact compare is selected
  function automatic logic [DATA_BITS-1:0] fold_byte(input logic [DATA_BITS-1:0] c,
                                                     input logic exact);
    logic [DATA_BITS-1:0] r;
    r = c;
    if (!exact && c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lgss_front.sv
`default_nettype none

module lgss_front #(
  parameter int PATTERN_MAX = 8,
  parameter int OFFSET_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  input  wire [lgss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire [lgss_pkg::PATTERN_BITS-1:0]    cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire [lgss_pkg::DATA_BITS-1:0]       in_byte,
  input  wire                                 in_last,
  input  wire                                 queue_ready,
  output logic                                push,
  output lgss_pkg::result_t                   push_item
);

  typedef logic [OFFSET_BITS-1:0] offset_t;

  logic [lgss_pkg::PATTERN_BITS-1:0] pattern_bytes;
  logic [lgss_pkg::LEN_BITS-1:0]     pattern_length;
  logic                              match_case;

  logic [lgss_pkg::DATA_BITS-1:0] window      [PATTERN_MAX];
  logic [lgss_pkg::DATA_BITS-1:0] window_next [PATTERN_MAX];
  logic [lgss_pkg::LINE_BITS-1:0] current_line;
  offset_t                        line_start;
  offset_t                        bytes_seen;
  logic                           skipping_line;

  logic [lgss_pkg::LEN_BITS-1:0] len;
  logic [lgss_pkg::LEN_BITS-1:0] pidx;
  logic [PATTERN_MAX-1:0]        byte_ok;
  offset_t                       line_pos;
  offset_t                       seen_inc;
  logic                          long_enough;
  logic                          hit;
  logic                          accept;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
      match_case     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lgss_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        lgss_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[lgss_pkg::LEN_BITS-1:0];
        lgss_pkg::REG_MATCH_CASE:     match_case     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = queue_ready;
  assign accept   = in_valid && queue_ready;

  // effective pattern length, capped at the window depth
  assign len = (pattern_length > lgss_pkg::LEN_BITS'(PATTERN_MAX))
             ? lgss_pkg::LEN_BITS'(PATTERN_MAX) : pattern_length;

  // window with the incoming byte shifted in, compared against the pattern tail
  always_comb begin
    pidx = '0;
    window_next[0] = in_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pidx = len - lgss_pkg::LEN_BITS'(1) - lgss_pkg::LEN_BITS'(k);
      byte_ok[k] = (lgss_pkg::LEN_BITS'(k) >= len) ||
        (lgss_pkg::fold_byte(window_next[k], match_case) ==
         lgss_pkg::fold_byte(pattern_bytes[{pidx[2:0], 3'b000} +: 8], match_case));
    end
  end

  // position in line and match decision
  assign line_pos    = bytes_seen - line_start;
  assign long_enough = line_pos >= offset_t'(len - lgss_pkg::LEN_BITS'(1));
  assign hit         = !skipping_line && (len != '0) && long_enough && (&byte_ok);
  assign seen_inc    = (bytes_seen == '1) ? bytes_seen : bytes_seen + offset_t'(1);

  // result record for the queue
  always_comb begin
    push                        = accept && (hit || in_last);
    push_item.match_found       = hit;
    push_item.line_number       = hit ? current_line : '0;
    push_item.line_start_offset = hit ? lgss_pkg::OUT_OFS_BITS'(line_start) : '0;
    push_item.end_of_file       = in_last;
  end

  // per-file state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= '0;
      end
      current_line  <= lgss_pkg::LINE_BITS'(1);
      line_start    <= '0;
      bytes_seen    <= '0;
      skipping_line <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          window[k] <= '0;
        end
        current_line  <= lgss_pkg::LINE_BITS'(1);
        line_start    <= '0;
        bytes_seen    <= '0;
        skipping_line <= 1'b0;
      end else begin
        window     <= window_next;
        bytes_seen <= seen_inc;
        if (in_byte == lgss_pkg::NEWLINE_BYTE) begin
          if (current_line != '1) begin
            current_line <= current_line + lgss_pkg::LINE_BITS'(1);
          end
          line_start    <= seen_inc;
          skipping_line <= 1'b0;
        end else if (hit) begin
          skipping_line <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lgss_queue.sv
`default_nettype none

module lgss_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  lgss_pkg::result_t  push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output lgss_pkg::result_t  pop_item,
  input  wire                pop_ready
);

  lgss_pkg::result_t    entries [lgss_pkg::QUEUE_DEPTH];
  lgss_pkg::queue_ptr_t wr_ptr;
  lgss_pkg::queue_ptr_t rd_ptr;
  lgss_pkg::queue_cnt_t count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count < lgss_pkg::queue_cnt_t'(lgss_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + lgss_pkg::queue_ptr_t'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + lgss_pkg::queue_ptr_t'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + lgss_pkg::queue_cnt_t'(1);
      end else if (do_pop && !do_push) begin
        count <= count - lgss_pkg::queue_cnt_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lgss_back.sv
`default_nettype none

module lgss_back (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  lgss_pkg::result_t                  in_item,
  output logic                               in_ready,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [lgss_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  lgss_pkg::result_t out_item;
  logic              out_valid;

  // output register loads when empty or being drained
  assign in_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= in_item;
    end
  end

  // pack result onto the stream
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_item.line_start_offset, out_item.line_number};
  assign m_axis_tuser  = out_item.match_found;
  assign m_axis_tlast  = out_item.end_of_file;

endmodule

`default_nettype wire

>>> rtl/line_grep_substring_search_unit.sv
// Streaming substring search over the bytes of a file, reporting matching lines.
// s_axis carries one file byte per item; tlast marks the final byte of the file.
// cfg_* writes the pattern (index 0), its length (index 1, 0 disables matching)
// and the exact-case flag (index 2); write only while no results are pending.
// m_axis gives at most one result per byte: on the first match in a line it
// carries the one-based line number and the line's start offset, and the final
// byte of a file always gives a result with tlast set (tuser low when no match).
// Throughput is one byte per cycle while the result queue has room: the window
// compare, counters and match decision for a byte all complete in the front's
// accept cycle. A result is written to the queue at its byte's accept edge and
// reaches m_axis through the output register once that is empty or drained.
// Results wait in a two-entry queue behind a one-item output register; when
// m_axis stalls, s_axis tready drops only once both are full.
// Synchronous reset clears the configuration, the window, the line counter
// (back to 1), the offsets and the queue; after the last byte of a file the
// per-file state returns to the same values.
`default_nettype none

module line_grep_substring_search_unit #(
  parameter int PATTERN_MAX = 8,
  parameter int OFFSET_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  // configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  // file bytes
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tlast,   // last_byte
  // results
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] line_number, [63:32] line_start_offset
  output logic        m_axis_tuser,   // [0] match_found
  output logic        m_axis_tlast    // end_of_file
);

  logic              queue_ready;
  logic              push;
  lgss_pkg::result_t push_item;
  logic              pop_valid;
  lgss_pkg::result_t pop_item;
  logic              pop_ready;

  assign cfg_ready = 1'b1;

  // front: accept bytes, window compare, line tracking
  lgss_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .queue_ready (queue_ready),
    .push        (push),
    .push_item   (push_item)
  );

  // result queue
  lgss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (queue_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // back: output register onto m_axis
  lgss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pop_valid),
    .in_item       (pop_item),
    .in_ready      (pop_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/lgss_checker.sv
`default_nettype none

`include "line_grep_substring_search_unit_assert.svh"

module lgss_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [63:0] m_axis_tdata,
  input  wire        m_axis_tuser,
  input  wire        m_axis_tlast
);

  // stalled result holds
  `LGSS_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a result without a match only comes from the end of a file
  `LGSS_ASSERT_NOW(a_nomatch_eof, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  // a result without a match carries zero line and offset
  `LGSS_ASSERT_NOW(a_nomatch_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 64'd0)
  // a match reports a one-based line
  `LGSS_ASSERT_NOW(a_match_line, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] != 32'd0)

endmodule

bind line_grep_substring_search_unit lgss_checker u_lgss_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/line_grep_result_checker.sv
`timescale 1ns / 100ps

module line_grep_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lgss_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]                       cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [63:0]                       m_axis_tdata,
  input  logic                              m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int                                mismatch_count,
  output int                                outstanding,
  output int                                reports_seen,
  output int                                hits_seen
);

  localparam int WINDOW_DEPTH = 8;

  // shadow of the configuration registers
  logic [63:0] search_pattern;
  logic [3:0]  search_length;
  logic        exact_case;

  // per-file search state
  logic [7:0]  window [WINDOW_DEPTH];
  logic [31:0] line_no;
  logic [31:0] line_base;
  logic [31:0] file_pos;
  logic        rest_of_line_skipped;

  lgss_pkg::result_t predicted_reports[$];
  int                errs = 0;
  int                n_reports = 0;
  int                n_hits = 0;

  function automatic logic [7:0] upper_if_folding(input logic [7:0] c);
    if (!exact_case && c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [31:0] bump_offset(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void clear_file();
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      window[k] = '0;
    end
    line_no              = 32'd1;
    line_base            = '0;
    file_pos             = '0;
    rest_of_line_skipped = 1'b0;
  endfunction

  // advance the search by one file byte; returns 1 when a report is due
  function automatic bit scan_file_byte(input logic [7:0] b, input logic eof,
                                        output lgss_pkg::result_t rep);
    logic [32:0] pos_in_line;
    int          n;
    bit          hit;
    logic [7:0]  pb;
    n = (search_length > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(search_length);
    pos_in_line = {1'b0, file_pos} - {1'b0, line_base} + 33'd1;
    for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = b;
    // newest byte lines up with the last pattern byte
    hit = 1'b0;
    if (!rest_of_line_skipped && n > 0 && pos_in_line >= 33'(n)) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        pb = search_pattern[8*(n-1-k) +: 8];
        if (upper_if_folding(window[k]) != upper_if_folding(pb)) begin
          hit = 1'b0;
        end
      end
    end
    rep = '0;
    if (hit) begin
      rep.match_found       = 1'b1;
      rep.line_number       = line_no;
      rep.line_start_offset = line_base;
      rest_of_line_skipped  = 1'b1;
    end
    if (b == lgss_pkg::NEWLINE_BYTE) begin
      if (line_no != '1) begin
        line_no = line_no + 32'd1;
      end
      line_base            = bump_offset(file_pos);
      rest_of_line_skipped = 1'b0;
    end
    file_pos = bump_offset(file_pos);
    rep.end_of_file = eof;
    if (eof) begin
      clear_file();
    end
    return hit || eof;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    lgss_pkg::result_t rep;
    lgss_pkg::result_t want;
    if (rst) begin
      search_pattern = '0;
      search_length  = '0;
      exact_case     = 1'b0;
      clear_file();
      predicted_reports.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lgss_pkg::REG_PATTERN_BYTES:  search_pattern = cfg_data;
          lgss_pkg::REG_PATTERN_LENGTH: search_length  = cfg_data[3:0];
          lgss_pkg::REG_MATCH_CASE:     exact_case     = cfg_data[0];
          default: ;
        endcase
      end
      // compare an outgoing item against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        n_reports++;
        if (m_axis_tuser) begin
          n_hits++;
        end
        if (predicted_reports.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none got match %0b line %0d ofs %0d eof %0b",
                   $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tlast);
        end else begin
          want = predicted_reports.pop_front();
          check_field("match_found", 32'(want.match_found), 32'(m_axis_tuser));
          check_field("line_number", want.line_number, m_axis_tdata[31:0]);
          check_field("line_start_offset", want.line_start_offset, m_axis_tdata[63:32]);
          check_field("end_of_file", 32'(want.end_of_file), 32'(m_axis_tlast));
        end
      end
      // predict from each accepted file byte
      if (s_axis_tvalid && s_axis_tready) begin
        if (scan_file_byte(s_axis_tdata, s_axis_tlast, rep)) begin
          predicted_reports.push_back(rep);
        end
      end
    end
    mismatch_count <= errs;
    outstanding    <= predicted_reports.size();
    reports_seen   <= n_reports;
    hits_seen      <= n_hits;
  end

endmodule

>>> sim/tb_line_grep_substring_search_unit.sv
`timescale 1ns / 100ps

module tb_line_grep_substring_search_unit;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_BYTES   = 750;
  localparam int CALM_TAIL      = 120;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [lgss_pkg::CFG_IDX_BITS-1:0] REG_SPARE_INDEX = 2'd3;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [lgss_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0]                       cfg_data;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [7:0]                        s_axis_tdata;
  logic                              s_axis_tlast;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [63:0]                       m_axis_tdata;
  logic                              m_axis_tuser;
  logic                              m_axis_tlast;

  int mismatch_count;
  int outstanding;
  int reports_seen;
  int hits_seen;

  int cycle_count = 0;
  int bytes_sent;
  int files_sent;
  int settings_used;
  bit gaps_on;
  int stall_left = 0;

  logic [7:0] file_bytes[$];

  line_grep_substring_search_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_grep_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .reports_seen   (reports_seen),
    .hits_seen      (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(1, 18)) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // filler text, with near misses taken from the pattern and some raw noise
  function automatic logic [7:0] filler_byte(input logic [63:0] pat, input int n);
    case ($urandom_range(0, 11))
      0:       return 8'h20;
      1, 2:    return 8'($urandom_range(8'h41, 8'h5A));
      3, 4, 5: return 8'($urandom_range(8'h61, 8'h7A));
      6:       return 8'($urandom_range(8'h30, 8'h39));
      7, 8:    return (n > 0) ? pat[8*$urandom_range(0, n-1) +: 8] : 8'h2E;
      9: begin
        // bytes right next to the letter ranges
        case ($urandom_range(0, 3))
          0:       return 8'h40;
          1:       return 8'h5B;
          2:       return 8'h60;
          default: return 8'h7B;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one copy of the pattern or a leading part of it, case flipped at random when folding
  task automatic put_pattern(input logic [63:0] pat, input int n, input logic exact,
                             input int upto);
    logic [7:0] c;
    for (int j = 0; j < upto; j++) begin
      c = pat[8*j +: 8];
      if (!exact && is_letter(c) && $urandom_range(0, 1) == 1) begin
        c = c ^ 8'h20;
      end
      file_bytes.push_back(c);
    end
  endtask

  // a file of short lines, most of them holding the pattern
  task automatic build_file(input logic [63:0] pat, input int n, input logic exact);
    int lines;
    lines = $urandom_range(1, 5);
    file_bytes.delete();
    for (int l = 0; l < lines; l++) begin
      repeat ($urandom_range(0, 10)) file_bytes.push_back(filler_byte(pat, n));
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        put_pattern(pat, n, exact, ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n);
        repeat ($urandom_range(0, 6)) file_bytes.push_back(filler_byte(pat, n));
        if ($urandom_range(0, 3) == 0) begin
          put_pattern(pat, n, exact, n);
        end
      end
      if (l != lines - 1 || $urandom_range(0, 1) == 1) begin
        file_bytes.push_back(lgss_pkg::NEWLINE_BYTE);
      end
    end
    if (file_bytes.size() == 0) begin
      file_bytes.push_back(filler_byte(pat, n));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    files_sent++;
  endtask

  // stop feeding bytes and let every predicted result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lgss_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper bits of the length and case writes carry junk
  task automatic load_settings(input logic [63:0] pat, input logic [3:0] len,
                               input logic exact, input bit poke_spare);
    logic [63:0] d;
    write_reg(lgss_pkg::REG_PATTERN_BYTES, pat);
    d = {$urandom, $urandom};
    d[3:0] = len;
    write_reg(lgss_pkg::REG_PATTERN_LENGTH, d);
    d = {$urandom, $urandom};
    d[0] = exact;
    write_reg(lgss_pkg::REG_MATCH_CASE, d);
    if (poke_spare) begin
      write_reg(REG_SPARE_INDEX, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic directed_file(input logic [7:0] text[$]);
    file_bytes = text;
    send_file();
  endtask

  initial begin
    logic [63:0] pat;
    logic [3:0]  len;
    logic        exact;
    int          n;
    int          phase_no;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    gaps_on       = 1'b1;
    bytes_sent    = 0;
    files_sent    = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // folded two-byte pattern: hit, skip rest of line, no hit across a newline,
    // extreme byte values, hit on the final byte of the file
    load_settings(64'h0000_0000_0000_6241, 4'd2, 1'b0, 1'b0);
    directed_file('{8'h00, 8'h61, 8'h42, 8'h61, 8'h62, lgss_pkg::NEWLINE_BYTE, 8'hFF,
                    8'h61, lgss_pkg::NEWLINE_BYTE, 8'h62, 8'h78, 8'h41, 8'h62});
    wait_drained();

    // exact case with a newline as last pattern byte, then a file with no hit
    load_settings(64'h0000_0000_0000_0A7A, 4'd2, 1'b1, 1'b1);
    directed_file('{8'h5A, lgss_pkg::NEWLINE_BYTE, 8'h7A, lgss_pkg::NEWLINE_BYTE, 8'h7A});
    directed_file('{8'h71});
    wait_drained();

    // random settings, each followed by a few files
    phase_no = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          for (int j = 0; j < 8; j++) begin
            pat[8*j +: 8] = filler_byte(64'h0, 0);
          end
        end
        3:       pat = {$urandom, $urandom};
        4:       pat = '0;
        default: pat = '1;
      endcase
      case ($urandom_range(0, 9))
        0:       len = 4'd0;
        8:       len = 4'($urandom_range(9, 15));
        9:       len = 4'd8;
        default: len = 4'($urandom_range(1, 8));
      endcase
      exact = 1'($urandom_range(0, 1));
      // make sure the register extremes come up early
      if (phase_no == 0) begin
        len = 4'd0;
      end else if (phase_no == 1) begin
        pat = '1;
        len = 4'd15;
      end else if (phase_no == 2) begin
        pat = '0;
        len = 4'd8;
      end
      n = (len > 8) ? 8 : int'(len);
      if (n > 0 && $urandom_range(0, 4) == 0) begin
        pat[8*(n-1) +: 8] = lgss_pkg::NEWLINE_BYTE;
      end
      gaps_on = (bytes_sent < RANDOM_BYTES - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      load_settings(pat, len, exact, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        build_file(pat, n, exact);
        send_file();
      end
      wait_drained();
      phase_no++;
    end

    gaps_on = 1'b0;
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d files under %0d register settings",
             bytes_sent, files_sent, settings_used);
    $display("checked %0d results, %0d of them line hits", reports_seen, hits_seen);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
